>>> sv/tsib_pkg.sv
package tsib_pkg;

  // Number of list slots, one cell per slot.
  localparam int unsigned CAPACITY = 64;

  // Field widths.
  localparam int unsigned KEY_W   = 32;
  localparam int unsigned DOC_W   = 31;
  localparam int unsigned ELEM_W  = 32;
  localparam int unsigned OP_W    = 2;
  localparam int unsigned SLOT_W  = 6;
  localparam int unsigned TOPK_W  = 7;
  localparam int unsigned TOTAL_W = 7;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 7;

  // Entry count must be able to hold CAPACITY itself.
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  // Wide enough to compare counts, slot numbers and top_k without loss.
  localparam int unsigned CMP_W = CNT_W + TOPK_W + SLOT_W;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd1;
  localparam logic [OP_W-1:0] OP_READ   = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SORT_DESC     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TOP_K         = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ELEMENT_LEVEL = 2'd2;

  localparam logic [TOPK_W-1:0] TOP_K_RESET = 7'd64;

  // One list entry, also the form of a candidate.
  typedef struct packed {
    logic signed [KEY_W-1:0]  key;
    logic        [DOC_W-1:0]  doc;
    logic signed [ELEM_W-1:0] elem;
  } entry_t;

  // Broadcast from the control to every cell of the chain.
  typedef struct packed {
    logic   ins;
    logic   desc;
    entry_t cand;
  } chain_ctrl_t;

endpackage

>>> sv/tsib_cell.sv
module tsib_cell
  import tsib_pkg::*;
(
  input  logic        clk_i,
  input  chain_ctrl_t ctrl_i,
  input  logic        occ_i,
  input  logic        tail_i,
  input  entry_t      prev_ent_i,
  input  logic        prev_beyond_i,
  output entry_t      ent_o,
  output logic        beyond_o
);

  entry_t ent_q, ent_d;
  logic   beyond;
  logic   take_new;
  logic   take_prev;

  // The stored key sorts after the candidate: the candidate goes in front of it.
  always_comb begin
    if (ctrl_i.desc) begin
      beyond = occ_i && ($signed(ent_q.key) < $signed(ctrl_i.cand.key));
    end else begin
      beyond = occ_i && ($signed(ent_q.key) > $signed(ctrl_i.cand.key));
    end
  end

  assign take_new  = ctrl_i.ins && !prev_beyond_i && (beyond || tail_i);
  assign take_prev = ctrl_i.ins && prev_beyond_i;

  always_comb begin
    ent_d = ent_q;
    if (take_new) begin
      ent_d = ctrl_i.cand;
    end else if (take_prev) begin
      ent_d = prev_ent_i;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign ent_o    = ent_q;
  assign beyond_o = beyond;

endmodule

>>> sv/tsib_chain.sv
module tsib_chain
  import tsib_pkg::*;
(
  input  logic              clk_i,
  input  chain_ctrl_t       ctrl_i,
  input  logic [CNT_W-1:0]  count_i,
  input  logic [SLOT_W-1:0] rd_slot_i,
  output logic              rd_hit_o,
  output entry_t            rd_ent_o
);

  entry_t ent   [CAPACITY];
  logic   beyond[CAPACITY];
  logic   occ   [CAPACITY];
  logic   tail  [CAPACITY];

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    entry_t prev_ent;
    logic   prev_beyond;

    assign occ[g]  = CMP_W'(g) < CMP_W'(count_i);
    assign tail[g] = CMP_W'(g) == CMP_W'(count_i);

    if (g == 0) begin : g_head
      assign prev_ent    = ent[g];
      assign prev_beyond = 1'b0;
    end else begin : g_body
      assign prev_ent    = ent[g-1];
      assign prev_beyond = beyond[g-1];
    end

    tsib_cell u_cell (
      .clk_i         (clk_i),
      .ctrl_i        (ctrl_i),
      .occ_i         (occ[g]),
      .tail_i        (tail[g]),
      .prev_ent_i    (prev_ent),
      .prev_beyond_i (prev_beyond),
      .ent_o         (ent[g]),
      .beyond_o      (beyond[g])
    );
  end

  // Slot select for reads; a slot past the fill or past the chain misses.
  always_comb begin
    rd_ent_o = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (CMP_W'(i) == CMP_W'(rd_slot_i)) begin
        rd_ent_o = ent[i];
      end
    end
  end

  assign rd_hit_o = (CMP_W'(rd_slot_i) < CMP_W'(count_i)) &&
                    (CMP_W'(rd_slot_i) < CMP_W'(CAPACITY));

endmodule

>>> sv/topk_sorted_insert_buffer_unit.sv
// Channel | Direction | Handshake                  | Payload
// --------+-----------+----------------------------+------------------------------------------
// in      | input     | in_valid_i / in_stall_o    | op, distance_key, doc_id, elem_pos,
//         |           |                            | passes_filter, read_slot
// out     | output    | out_valid_o / out_stall_i  | accepted, entry_total, full_res,
//         |           |                            | out_key, out_doc, out_elem
// cfg     | input     | cfg_we_i                   | cfg_idx_i, cfg_wdata_i
//
// Every word is accepted at a clock edge and its result word is valid right after that
// edge, so a new word can enter every cycle while the input is not stalled. This rests on the
// insertion chain, where every cell compares its key with the candidate in parallel and
// loads the candidate or its neighbor's entry at the same edge.
// Reset clears the entry count, the configuration and the output valid; the list storage
// itself is not cleared, since only slots below the entry count are ever read.
// The input is stalled only while a result word is held and the output is stalled.
module topk_sorted_insert_buffer_unit
  import tsib_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,

  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [CFG_DAT_W-1:0]     cfg_wdata_i,

  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [OP_W-1:0]          op_i,
  input  logic signed [KEY_W-1:0]  distance_key_i,
  input  logic [DOC_W-1:0]         doc_id_i,
  input  logic signed [ELEM_W-1:0] elem_pos_i,
  input  logic                     passes_filter_i,
  input  logic [SLOT_W-1:0]        read_slot_i,

  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic                     accepted_o,
  output logic [TOTAL_W-1:0]       entry_total_o,
  output logic                     full_res_o,
  output logic signed [KEY_W-1:0]  out_key_o,
  output logic [DOC_W-1:0]         out_doc_o,
  output logic signed [ELEM_W-1:0] out_elem_o
);

  // Configuration registers.
  logic              sort_desc_q;
  logic [TOPK_W-1:0] top_k_q;
  logic              element_level_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sort_desc_q     <= 1'b0;
      top_k_q         <= TOP_K_RESET;
      element_level_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_SORT_DESC:     sort_desc_q     <= cfg_wdata_i[0];
        REG_TOP_K:         top_k_q         <= cfg_wdata_i[TOPK_W-1:0];
        REG_ELEMENT_LEVEL: element_level_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Handshake. The output register holds one result word; a new input word is
  // taken whenever that register is empty or is being drained in this cycle.
  logic out_valid_q;
  logic in_fire;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_fire    = in_valid_i && !in_stall_o;

  // The fill limit is top_k saturated at the chain length.
  logic [CMP_W-1:0] limit;
  logic [CNT_W-1:0] count_q, count_d;
  logic             room;
  logic             do_insert;

  assign limit = (CMP_W'(top_k_q) > CMP_W'(CAPACITY)) ? CMP_W'(CAPACITY) : CMP_W'(top_k_q);
  assign room  = CMP_W'(count_q) < limit;
  assign do_insert = in_fire && (op_i == OP_INSERT) && passes_filter_i && room;

  always_comb begin
    count_d = count_q;
    if (do_insert) begin
      count_d = count_q + CNT_W'(1);
    end else if (in_fire && (op_i == OP_CLEAR)) begin
      count_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // Candidate broadcast to the chain. Without element level, minus one is stored.
  chain_ctrl_t chain_ctrl;
  logic        rd_hit;
  entry_t      rd_ent;

  always_comb begin
    chain_ctrl.ins       = do_insert;
    chain_ctrl.desc      = sort_desc_q;
    chain_ctrl.cand.key  = distance_key_i;
    chain_ctrl.cand.doc  = doc_id_i;
    chain_ctrl.cand.elem = element_level_q ? elem_pos_i : '1;
  end

  tsib_chain u_chain (
    .clk_i     (clk_i),
    .ctrl_i    (chain_ctrl),
    .count_i   (count_q),
    .rd_slot_i (read_slot_i),
    .rd_hit_o  (rd_hit),
    .rd_ent_o  (rd_ent)
  );

  // Result register. A read takes the list as it stood before this word; the
  // counts report the state after it.
  logic                     accepted_q;
  logic [TOTAL_W-1:0]       total_q;
  logic                     full_q;
  logic signed [KEY_W-1:0]  key_q;
  logic [DOC_W-1:0]         doc_q;
  logic signed [ELEM_W-1:0] elem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      accepted_q <= do_insert;
      total_q    <= TOTAL_W'(count_d);
      full_q     <= CMP_W'(count_d) >= limit;
      if (op_i == OP_READ) begin
        if (rd_hit) begin
          key_q  <= rd_ent.key;
          doc_q  <= rd_ent.doc;
          elem_q <= rd_ent.elem;
        end else begin
          key_q  <= '0;
          doc_q  <= '0;
          elem_q <= '1;
        end
      end else begin
        key_q  <= '0;
        doc_q  <= '0;
        elem_q <= '0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign accepted_o    = accepted_q;
  assign entry_total_o = total_q;
  assign full_res_o    = full_q;
  assign out_key_o     = key_q;
  assign out_doc_o     = doc_q;
  assign out_elem_o    = elem_q;

`ifndef SYNTHESIS
  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CMP_W'(count_q) <= CMP_W'(CAPACITY))
    else $error("entry count above capacity");

  a_insert_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_insert |=> (count_q == $past(count_q) + CNT_W'(1)))
    else $error("insert did not advance entry count");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (op_i == OP_CLEAR)) |=> (count_q == '0))
    else $error("clear did not empty list");

  a_accept_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && accepted_q) |-> (total_q != '0))
    else $error("accepted word reports empty list");
`endif

endmodule

>>> verif/topk_sorted_insert_buffer_checker.sv
`timescale 1ns / 100ps

// Watches the input, output and register channels of the sorted top-k list.
// It keeps its own copy of the list and the registers, predicts one result word
// per accepted input word, and compares every accepted result word with the oldest
// prediction.
module topk_sorted_insert_buffer_checker
  import tsib_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,

  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [CFG_DAT_W-1:0]     cfg_wdata_i,

  input  logic                     in_valid_i,
  input  logic                     in_stall_i,
  input  logic [OP_W-1:0]          op_i,
  input  logic signed [KEY_W-1:0]  distance_key_i,
  input  logic [DOC_W-1:0]         doc_id_i,
  input  logic signed [ELEM_W-1:0] elem_pos_i,
  input  logic                     passes_filter_i,
  input  logic [SLOT_W-1:0]        read_slot_i,

  input  logic                     out_valid_i,
  input  logic                     out_stall_i,
  input  logic                     accepted_i,
  input  logic [TOTAL_W-1:0]       entry_total_i,
  input  logic                     full_res_i,
  input  logic signed [KEY_W-1:0]  out_key_i,
  input  logic [DOC_W-1:0]         out_doc_i,
  input  logic signed [ELEM_W-1:0] out_elem_i,

  output int                       fail_count_o,
  output int                       pending_o,
  output int                       checked_o
);

  typedef struct packed {
    logic                     accepted;
    logic [TOTAL_W-1:0]       total;
    logic                     full;
    logic signed [KEY_W-1:0]  key;
    logic [DOC_W-1:0]         doc;
    logic signed [ELEM_W-1:0] elem;
  } list_result_t;

  entry_t            ranked_list [CAPACITY];
  int                list_fill;
  logic              order_desc;
  logic [TOPK_W-1:0] wanted_k;
  logic              keep_elem;
  list_result_t      predicted_results [$];
  int                mismatches = 0;
  int                results_seen = 0;

  task automatic apply_list_op(input logic [OP_W-1:0] op,
                               input logic signed [KEY_W-1:0] key,
                               input logic [DOC_W-1:0] doc,
                               input logic signed [ELEM_W-1:0] elem,
                               input logic filt,
                               input logic [SLOT_W-1:0] slot);
    int           limit;
    int           pos;
    list_result_t res;
    limit = (wanted_k > CAPACITY) ? CAPACITY : int'(wanted_k);
    res = '0;
    case (op)
      OP_INSERT: begin
        if (filt && list_fill < limit) begin
          // The new entry lands after every entry with an equal key.
          pos = list_fill;
          for (int i = 0; i < list_fill; i++) begin
            if (order_desc ? (ranked_list[i].key < key) : (ranked_list[i].key > key)) begin
              pos = i;
              break;
            end
          end
          for (int i = list_fill; i > pos; i--) begin
            ranked_list[i] = ranked_list[i-1];
          end
          ranked_list[pos].key  = key;
          ranked_list[pos].doc  = doc;
          ranked_list[pos].elem = keep_elem ? elem : '1;
          list_fill++;
          res.accepted = 1'b1;
        end
      end
      OP_CLEAR: begin
        list_fill = 0;
      end
      OP_READ: begin
        if (int'(slot) < list_fill) begin
          res.key  = ranked_list[slot].key;
          res.doc  = ranked_list[slot].doc;
          res.elem = ranked_list[slot].elem;
        end else begin
          res.elem = '1;
        end
      end
      default: ;
    endcase
    res.total = TOTAL_W'(list_fill);
    res.full  = (list_fill >= limit);
    predicted_results.insert(predicted_results.size(), res);
  endtask

  task automatic check_result();
    list_result_t got;
    list_result_t want;
    got = '{accepted_i, entry_total_i, full_res_i, out_key_i, out_doc_i, out_elem_i};
    results_seen++;
    if (predicted_results.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("ERROR at %0t: result word arrived with no prediction waiting", $time);
      end
    end else begin
      want = predicted_results.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("ERROR at %0t: result %0d differs", $time, results_seen);
          $display("  expected accepted=%0b total=%0d full=%0b key=%h doc=%h elem=%h",
                   want.accepted, want.total, want.full, want.key, want.doc, want.elem);
          $display("  actual   accepted=%0b total=%0d full=%0b key=%h doc=%h elem=%h",
                   got.accepted, got.total, got.full, got.key, got.doc, got.elem);
        end
      end
    end
  endtask

  // Sampling happens at the clock edge, before any of the edge's updates land.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      list_fill  = 0;
      order_desc = 1'b0;
      wanted_k   = TOP_K_RESET;
      keep_elem  = 1'b0;
      predicted_results.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        check_result();
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_SORT_DESC:     order_desc = cfg_wdata_i[0];
          REG_TOP_K:         wanted_k   = cfg_wdata_i[TOPK_W-1:0];
          REG_ELEMENT_LEVEL: keep_elem  = cfg_wdata_i[0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        apply_list_op(op_i, distance_key_i, doc_id_i, elem_pos_i, passes_filter_i,
                      read_slot_i);
      end
    end
    fail_count_o <= mismatches;
    pending_o    <= predicted_results.size();
    checked_o    <= results_seen;
  end

endmodule

>>> verif/tb_topk_sorted_insert_buffer_unit.sv
`timescale 1ns / 100ps

// Testbench top for the sorted top-k insertion list. This module only makes
// stimulus and gives the verdict; all prediction and comparison lives in the
// checker instantiated beside the block.
module tb_topk_sorted_insert_buffer_unit;
  import tsib_pkg::*;

  // The op code the block must treat as a no-op, and the register index that
  // names no register. Neither has a name in the package.
  localparam logic [OP_W-1:0]      OP_UNDEF  = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  // Random words per register setting, and the length of the long output hold.
  localparam int PHASE_WORDS = 128;
  localparam int NUM_PHASES  = 12;
  localparam int LONG_HOLD   = 300;

  typedef enum {IDLE_OFF, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

  logic clk_i;
  logic rst_n = 1'b0;

  logic                     cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_idx   = '0;
  logic [CFG_DAT_W-1:0]     cfg_wdata = '0;

  logic                     in_valid  = 1'b0;
  logic                     in_stall;
  logic [OP_W-1:0]          op        = OP_INSERT;
  logic signed [KEY_W-1:0]  dist_key  = '0;
  logic [DOC_W-1:0]         doc_id    = '0;
  logic signed [ELEM_W-1:0] cand_elem = '0;
  logic                     filt      = 1'b0;
  logic [SLOT_W-1:0]        rd_slot   = '0;

  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic                     accepted;
  logic [TOTAL_W-1:0]       entry_total;
  logic                     full_res;
  logic signed [KEY_W-1:0]  out_key;
  logic [DOC_W-1:0]         out_doc;
  logic signed [ELEM_W-1:0] out_elem;

  int fail_count;
  int pending;
  int checked;

  // Idle rates. The sender rate belongs to the stimulus process alone; the
  // receiver rate and the hold request are handed to the stall process with
  // nonblocking writes so that it reads them without racing.
  int send_pct   = 0;
  int recv_pct   = 0;
  int hold_token = 0;

  // What the stimulus knows of the current registers, used only to size queries.
  int cur_topk   = TOP_K_RESET;
  int n_words    = 0;
  int n_settings = 0;

  topk_sorted_insert_buffer_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .op_i            (op),
    .distance_key_i  (dist_key),
    .doc_id_i        (doc_id),
    .elem_pos_i      (cand_elem),
    .passes_filter_i (filt),
    .read_slot_i     (rd_slot),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .accepted_o      (accepted),
    .entry_total_o   (entry_total),
    .full_res_o      (full_res),
    .out_key_o       (out_key),
    .out_doc_o       (out_doc),
    .out_elem_o      (out_elem)
  );

  topk_sorted_insert_buffer_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .op_i            (op),
    .distance_key_i  (dist_key),
    .doc_id_i        (doc_id),
    .elem_pos_i      (cand_elem),
    .passes_filter_i (filt),
    .read_slot_i     (rd_slot),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .accepted_i      (accepted),
    .entry_total_i   (entry_total),
    .full_res_i      (full_res),
    .out_key_i       (out_key),
    .out_doc_i       (out_doc),
    .out_elem_i      (out_elem),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .checked_o       (checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // A healthy run ends far sooner than this timeout.
  initial begin
    #1_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // Receiver side. Normally it stalls at the rate of the current idle mode.
  // When the stimulus asks for a long hold, it keeps the output stalled for a
  // fixed stretch counted here, so the result register fills and the block
  // stalls its input while the sender keeps offering words.
  initial begin
    int hold_seen;
    hold_seen = 0;
    forever begin
      @(posedge clk_i);
      if (hold_token != hold_seen) begin
        hold_seen = hold_token;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk_i);
      end else begin
        out_stall <= (recv_pct != 0) && ($urandom_range(99) < recv_pct);
      end
    end
  end

  // Keys are mostly drawn from narrow sets so that equal keys are common, and
  // now and then from the extremes of the signed Q16.16 range.
  function automatic logic signed [KEY_W-1:0] rand_key();
    logic signed [KEY_W-1:0] k;
    case ($urandom_range(3))
      0: k = $urandom;
      1: k = ($signed($urandom_range(6)) - 3) <<< 16;
      2: begin
        case ($urandom_range(3))
          0: k = 32'sh8000_0000;
          1: k = 32'sh7FFF_FFFF;
          2: k = '0;
          default: k = -1;
        endcase
      end
      default: k = $signed($urandom_range(2000)) - 1000;
    endcase
    return k;
  endfunction

  // Element indexes stay in their legal range: minus one, or non-negative.
  function automatic logic signed [ELEM_W-1:0] rand_elem();
    logic [ELEM_W-1:0] e;
    e = $urandom;
    return ($urandom_range(9) == 0) ? -1 : $signed({1'b0, e[ELEM_W-2:0]});
  endfunction

  // Offers one word and returns once it has been accepted. The sender may go
  // idle first; valid stays high from one word to the next otherwise.
  task automatic send_word(input logic [OP_W-1:0] w_op,
                           input logic signed [KEY_W-1:0] w_key,
                           input logic [DOC_W-1:0] w_doc,
                           input logic signed [ELEM_W-1:0] w_elem,
                           input logic w_filt,
                           input logic [SLOT_W-1:0] w_slot);
    while ((send_pct != 0) && ($urandom_range(99) < send_pct)) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid  <= 1'b1;
    op        <= w_op;
    dist_key  <= w_key;
    doc_id    <= w_doc;
    cand_elem <= w_elem;
    filt      <= w_filt;
    rd_slot   <= w_slot;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    n_words++;
  endtask

  // Lets every expected result word arrive. The first edge makes sure the
  // checker's count already includes the last accepted word.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk_i);
  endtask

  // Writes all registers once the block is idle. The one-bit registers get
  // random upper bits, which the block must ignore, and the spare index gets a
  // random write that must change nothing.
  task automatic apply_setting(input logic desc, input int k, input logic el,
                               input idle_mode_e mode);
    logic [CFG_DAT_W-1:0] junk;
    wait_drained();
    junk = $urandom;
    write_reg(REG_SPARE, junk);
    junk = $urandom;
    write_reg(REG_SORT_DESC, {junk[CFG_DAT_W-1:1], desc});
    write_reg(REG_TOP_K, CFG_DAT_W'(k));
    junk = $urandom;
    write_reg(REG_ELEMENT_LEVEL, {junk[CFG_DAT_W-1:1], el});
    cfg_we   <= 1'b0;
    cur_topk = k;
    n_settings++;
    send_pct = (mode == IDLE_SEND) ? 66 : (mode == IDLE_BOTH) ? 10 : 0;
    recv_pct <= (mode == IDLE_RECV) ? 66 : (mode == IDLE_BOTH) ? 10 : 0;
  endtask

  // One query: usually a clear, then a run of candidates with some filtered
  // ones, undefined ops and reads mixed in, then a read sweep over the list.
  // Sizes reach a little past the fill limit so the full case is hit often.
  // Skipping the clear now and then keeps an old list across a register change.
  task automatic run_query();
    int limit;
    int n_ins;
    int sweep;
    int pick;
    limit = (cur_topk > CAPACITY) ? CAPACITY : cur_topk;
    if ($urandom_range(99) < 85) begin
      send_word(OP_CLEAR, rand_key(), DOC_W'($urandom), rand_elem(), 1'($urandom),
                SLOT_W'($urandom));
    end
    n_ins = $urandom_range(1, limit + 4);
    for (int i = 0; i < n_ins; i++) begin
      pick = $urandom_range(99);
      if (pick < 4) begin
        send_word(OP_UNDEF, rand_key(), DOC_W'($urandom), rand_elem(), 1'($urandom),
                  SLOT_W'($urandom));
      end else if (pick < 10) begin
        send_word(OP_INSERT, rand_key(), DOC_W'($urandom), rand_elem(), 1'b0,
                  SLOT_W'($urandom));
      end else if (pick < 25) begin
        send_word(OP_READ, rand_key(), DOC_W'($urandom), rand_elem(), 1'($urandom),
                  SLOT_W'($urandom_range((limit > 63) ? 63 : limit)));
      end else begin
        send_word(OP_INSERT, rand_key(), DOC_W'($urandom), rand_elem(), 1'b1,
                  SLOT_W'($urandom));
      end
    end
    sweep = (n_ins + 1 > 63) ? 63 : n_ins + 1;
    for (int s = 0; s <= sweep; s++) begin
      send_word(OP_READ, rand_key(), DOC_W'($urandom), rand_elem(), 1'($urandom),
                SLOT_W'(s));
    end
  endtask

  // Short directed opening under the reset settings: ascending order, no
  // element indexes stored. It reads an empty list, sends an undefined op and a
  // filtered candidate, inserts the extreme keys and a run of equal keys, reads
  // the result back, reads again after a clear, and inserts and reads one more entry.
  task automatic run_directed();
    send_word(OP_READ,   '0, '0, '0, 1'b0, 6'd0);
    send_word(OP_READ,   '0, '0, '0, 1'b0, 6'd63);
    send_word(OP_UNDEF,  32'sh0001_0000, 31'h7FFF_FFFF, '0, 1'b1, 6'd0);
    send_word(OP_INSERT, 32'sh0000_0005, 31'd9, 32'sd9, 1'b0, 6'd0);
    send_word(OP_INSERT, 32'sh7FFF_FFFF, 31'h7FFF_FFFF, 32'sh7FFF_FFFF, 1'b1, 6'd0);
    send_word(OP_INSERT, 32'sh8000_0000, 31'd0, -32'sd1, 1'b1, 6'd0);
    send_word(OP_INSERT, 32'sh0000_0000, 31'd1, 32'sd0, 1'b1, 6'd0);
    send_word(OP_INSERT, 32'sh0000_0000, 31'd2, 32'sd5, 1'b1, 6'd0);
    send_word(OP_INSERT, 32'sh0000_0000, 31'd3, 32'sd6, 1'b1, 6'd0);
    send_word(OP_INSERT, -32'sd1, 31'd4, 32'sd7, 1'b1, 6'd0);
    send_word(OP_INSERT, 32'sh0001_0000, 31'd5, 32'sd8, 1'b1, 6'd0);
    for (int s = 0; s < 8; s++) begin
      send_word(OP_READ, '0, '0, '0, 1'b0, SLOT_W'(s));
    end
    send_word(OP_CLEAR,  '0, '0, '0, 1'b0, 6'd0);
    send_word(OP_READ,   '0, '0, '0, 1'b0, 6'd0);
    send_word(OP_INSERT, 32'sh0000_0005, 31'd6, 32'sd1, 1'b1, 6'd0);
    send_word(OP_READ,   '0, '0, '0, 1'b0, 6'd0);
  endtask

  initial begin
    logic       p_desc;
    int         p_k;
    logic       p_el;
    idle_mode_e p_mode;
    int         start_words;

    repeat (12) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // Register settings cover both orders, both element modes, and top_k at
    // zero, one, two, just below, at and above the capacity, and at its
    // maximum code; the last few settings are random.
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin p_desc = 1'b0; p_k = 64;  p_el = 1'b0; p_mode = IDLE_OFF;  end
        1: begin p_desc = 1'b1; p_k = 64;  p_el = 1'b1; p_mode = IDLE_OFF;  end
        2: begin p_desc = 1'b0; p_k = 1;   p_el = 1'b1; p_mode = IDLE_SEND; end
        3: begin p_desc = 1'b1; p_k = 0;   p_el = 1'b0; p_mode = IDLE_RECV; end
        4: begin p_desc = 1'b0; p_k = 127; p_el = 1'b1; p_mode = IDLE_BOTH; end
        5: begin p_desc = 1'b1; p_k = 65;  p_el = 1'b0; p_mode = IDLE_SEND; end
        6: begin p_desc = 1'b0; p_k = 2;   p_el = 1'b1; p_mode = IDLE_RECV; end
        7: begin p_desc = 1'b1; p_k = 63;  p_el = 1'b1; p_mode = IDLE_BOTH; end
        8: begin p_desc = 1'b0; p_k = 64;  p_el = 1'b1; p_mode = IDLE_RECV; end
        default: begin
          p_desc = 1'($urandom);
          p_k    = ($urandom_range(3) == 0) ? $urandom_range(127) : $urandom_range(12);
          p_el   = 1'($urandom);
          p_mode = idle_mode_e'(p % 4);
        end
      endcase
      apply_setting(p_desc, p_k, p_el, p_mode);

      if (p == 0) begin
        run_directed();
        // Pause the sender until every result of the opening has come back.
        wait_drained();
      end
      if (p == 1) begin
        // Long output hold while the sender streams without gaps.
        hold_token <= hold_token + 1;
      end

      start_words = n_words;
      while (n_words - start_words < PHASE_WORDS) begin
        run_query();
      end
    end

    wait_drained();
    repeat (4) @(posedge clk_i);

    $display("Run covered %0d input words and %0d checked result words over %0d settings,",
             n_words, checked, n_settings);
    $display("both sort orders, top_k from zero to its maximum, gaps, stalls and a long hold.");
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/tsib_pkg.sv
sv/tsib_cell.sv
sv/tsib_chain.sv
sv/topk_sorted_insert_buffer_unit.sv
verif/topk_sorted_insert_buffer_checker.sv
verif/tb_topk_sorted_insert_buffer_unit.sv
